// ----- hw/rtl/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the serial frame deframer
// Holds the configuration record, the classified item passed from the parser
// to the result stage, the register indexes and the reset values.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned SFD_QUEUE_DEPTH = 4;

  localparam logic [7:0] SFD_PREAMBLE_RST  = 8'hFE;
  localparam logic [7:0] SFD_POSTAMBLE_RST = 8'hFD;
  localparam logic [7:0] SFD_ACK_RST       = 8'hFA;
  localparam logic [7:0] SFD_NACK_RST      = 8'hFB;

  typedef enum logic [1:0] {
    CFG_PREAMBLE  = 2'd0,
    CFG_POSTAMBLE = 2'd1,
    CFG_ACK       = 2'd2,
    CFG_NACK      = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] preamble_code;
    logic [7:0] postamble_code;
    logic [7:0] ack_code;
    logic [7:0] nack_code;
  } cfg_t;

  // What the parser decided about one received byte.
  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_FWD_FIRST = 3'd1,
    OP_FWD       = 3'd2,
    OP_END_DATA  = 3'd3,
    OP_END_ACK   = 3'd4,
    OP_END_NACK  = 3'd5,
    OP_END_BAD   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    STATUS_GOOD = 2'd0,
    STATUS_ACK  = 2'd1,
    STATUS_NACK = 2'd2,
    STATUS_BAD  = 2'd3
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } sfd_item_t;

endpackage

// ----- hw/rtl/sfd_front.sv -----
// ----------------------------------------------------------------------------
// sfd_front: frame parser
// Takes one received byte per item, tracks the frame layout and pushes one
// classified item per byte into the queue.
// ----------------------------------------------------------------------------
module sfd_front (
  input  logic              clk,
  input  logic              rst,
  input  sfd_pkg::cfg_t     cfg,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  output logic              push_valid,
  input  logic              push_ready,
  output sfd_pkg::sfd_item_t push_item
);
  import sfd_pkg::*;

  typedef enum logic [5:0] {
    PH_HUNT1 = 6'b000001,
    PH_HUNT2 = 6'b000010,
    PH_CMD   = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_TERM  = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NACK = 2'd2
  } kind_t;

  phase_t     phase, phase_next;
  kind_t      kind, kind_next;
  logic [7:0] bytes_left, bytes_left_next;
  op_t        op;
  logic       accept;

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;
  assign accept     = s_tvalid && push_ready;
  assign push_item  = '{op: op, data: s_tdata};

  always_comb begin
    phase_next      = phase;
    kind_next       = kind;
    bytes_left_next = bytes_left;
    op              = OP_NONE;
    unique case (phase)
      PH_HUNT2: begin
        phase_next = (s_tdata == cfg.preamble_code) ? PH_CMD : PH_HUNT1;
      end
      PH_CMD: begin
        // Further preamble bytes keep the parser waiting for the command.
        if (s_tdata != cfg.preamble_code) begin
          if (s_tdata == cfg.ack_code) begin
            kind_next = KIND_ACK;
          end else if (s_tdata == cfg.nack_code) begin
            kind_next = KIND_NACK;
          end else begin
            kind_next = KIND_DATA;
            op        = OP_FWD_FIRST;
          end
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        bytes_left_next = s_tdata;
        if (kind == KIND_DATA) begin
          op = OP_FWD;
        end
        phase_next = (s_tdata == 8'd0) ? PH_TERM : PH_DATA;
      end
      PH_DATA: begin
        if (kind == KIND_DATA) begin
          op = OP_FWD;
        end
        bytes_left_next = bytes_left - 8'd1;
        if (bytes_left == 8'd1) begin
          phase_next = PH_TERM;
        end
      end
      PH_TERM: begin
        if (s_tdata == cfg.postamble_code) begin
          case (kind)
            KIND_DATA: op = OP_END_DATA;
            KIND_ACK:  op = OP_END_ACK;
            default:   op = OP_END_NACK;
          endcase
        end else begin
          op = OP_END_BAD;
        end
        phase_next      = PH_HUNT1;
        bytes_left_next = 8'd0;
      end
      default: begin
        phase_next = (s_tdata == cfg.preamble_code) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT1;
      kind       <= KIND_DATA;
      bytes_left <= 8'd0;
    end else if (accept) begin
      phase      <= phase_next;
      kind       <= kind_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

// ----- hw/rtl/sfd_queue.sv -----
// ----------------------------------------------------------------------------
// sfd_queue: short queue between parser and result stage
// Holds classified items so that either side can stall on its own.
// ----------------------------------------------------------------------------
module sfd_queue #(
  parameter int unsigned DEPTH = sfd_pkg::SFD_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  sfd_pkg::sfd_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output sfd_pkg::sfd_item_t pop_item
);
  import sfd_pkg::*;

  localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sfd_item_t     mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          push, pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");

endmodule

// ----- hw/rtl/sfd_back.sv -----
// ----------------------------------------------------------------------------
// sfd_back: result stage
// Turns each classified item into the result fields and holds them in the
// output register until the downstream side takes them.
// ----------------------------------------------------------------------------
module sfd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  sfd_pkg::sfd_item_t pop_item,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,
  output logic               m_tlast
);
  import sfd_pkg::*;

  logic       load;
  logic       out_valid, out_first, frame_end, release_tx_head;
  logic [7:0] out_byte;
  status_t    frame_status;

  assign pop_ready = !m_tvalid || m_tready;
  assign load      = pop_valid && pop_ready;

  always_comb begin
    out_valid       = 1'b0;
    out_first       = 1'b0;
    out_byte        = 8'd0;
    frame_end       = 1'b0;
    frame_status    = STATUS_GOOD;
    release_tx_head = 1'b0;
    unique case (pop_item.op)
      OP_FWD_FIRST, OP_FWD: begin
        out_valid = 1'b1;
        out_first = (pop_item.op == OP_FWD_FIRST);
        out_byte  = pop_item.data;
      end
      OP_END_DATA, OP_END_ACK: begin
        frame_end       = 1'b1;
        frame_status    = (pop_item.op == OP_END_ACK) ? STATUS_ACK : STATUS_GOOD;
        release_tx_head = 1'b1;
      end
      OP_END_NACK: begin
        frame_end    = 1'b1;
        frame_status = STATUS_NACK;
      end
      OP_END_BAD: begin
        frame_end    = 1'b1;
        frame_status = STATUS_BAD;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop_ready) begin
      m_tvalid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {3'b000, release_tx_head, frame_status, out_first, out_byte, out_valid};
      m_tlast <= frame_end;
    end
  end

  a_fwd_not_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tlast))
    else $error("forwarded byte marked as frame end");

  a_release_at_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[12]) |-> (m_tlast && m_tdata[11:10] != STATUS_NACK
                                   && m_tdata[11:10] != STATUS_BAD))
    else $error("release outside a good frame end");

  a_status_at_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[11:10] == STATUS_GOOD && !m_tdata[12]))
    else $error("status or release without frame end");

endmodule

// ----- hw/rtl/serial_frame_deframer_ack.sv -----
// ----------------------------------------------------------------------------
// serial_frame_deframer_ack: length-prefixed frame deframer with ACK handling
//
//   Channel  Direction  Signals                      Content
//   s_*      in         s_tvalid s_tready s_tdata    one received byte
//   m_*      out        m_tvalid m_tready m_tdata    one result per byte
//                       m_tlast                      frame end
//   cfg_*    in         cfg_we cfg_index cfg_data    register writes
//
// One byte is taken per cycle while s_tready is high; its result passes
// through the queue and then the output register.
// The queue lets the parser keep accepting bytes while the output is
// stalled; s_tready falls only when the queue is full.
// Reset restores the register defaults and puts the parser in hunting.
// ----------------------------------------------------------------------------
module serial_frame_deframer_ack #(
  parameter int unsigned QUEUE_DEPTH = sfd_pkg::SFD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] out_valid, [8:1] out_byte, [9] out_first, [11:10] frame_status,
  // [12] release_tx_head, [15:13] zero
  output logic [15:0] m_tdata,
  output logic        m_tlast,   // frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import sfd_pkg::*;

  cfg_t      cfg;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  sfd_item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preamble_code  <= SFD_PREAMBLE_RST;
      cfg.postamble_code <= SFD_POSTAMBLE_RST;
      cfg.ack_code       <= SFD_ACK_RST;
      cfg.nack_code      <= SFD_NACK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PREAMBLE:  cfg.preamble_code  <= cfg_data;
        CFG_POSTAMBLE: cfg.postamble_code <= cfg_data;
        CFG_ACK:       cfg.ack_code       <= cfg_data;
        CFG_NACK:      cfg.nack_code      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  sfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
